// ===== src/urr_pkg.sv =====
// Shared types and constants of the ultrasonic round-robin ranger.
`timescale 1ns / 1ps

package urr_pkg;

  localparam int NUM_SENSORS_DEF = 3;

  localparam logic [19:0] RESET_TIMEOUT = 20'd30000;
  localparam logic [9:0]  RESET_DIST    = 10'd400;
  localparam logic [9:0]  DIST_MAX      = 10'd1023;

  // pulse / 58 by reciprocal multiply, exact below the saturation limit
  localparam int          CM_DIVISOR  = 58;
  localparam int          DIST_MAX_I  = 1023;
  localparam int          RECIP_SHIFT = 21;
  localparam logic [15:0] RECIP_MULT  = 16'((2**RECIP_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR);
  localparam logic [31:0] SAT_LIMIT   = 32'((DIST_MAX_I + 1) * CM_DIVISOR);

  localparam int ADDR_W = 3;

  typedef enum logic [0:0] {
    OP_POLL = 1'b0,
    OP_ECHO = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_NO_ECHO = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] timeout_us;
    logic [9:0]  no_echo_cm;
  } cfg_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [1:0]  sensor_index;
    logic        echo_level;
    logic [31:0] time_us;
  } item_t;

  typedef struct packed {
    logic        fire_trigger;
    logic [1:0]  fired_sensor;
    logic [9:0]  dist_left_cm;
    logic [9:0]  dist_center_cm;
    logic [9:0]  dist_right_cm;
  } result_t;

endpackage

// ===== src/ultrasonic_round_robin_ranger_unit.sv =====
// Top level of the ultrasonic round-robin ranger: handshake stages, core, registers.
`timescale 1ns / 1ps
// Path: an accepted word is held in the input register, then its result is loaded into the result register.
// Throughput: one word per cycle while out_ready is high; the input register feeds the core, whose
//   single-pass update lands in the result register as the state is written.
// Reset: synchronous, active low on rst_n; all sensors idle, distances 400 cm,
//   pointer at the left sensor, timeout 30000 us, no-echo distance 400 cm.

module ultrasonic_round_robin_ranger_unit #(
  parameter int NUM_SENSORS = urr_pkg::NUM_SENSORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [1:0]                 in_sensor_index,
  input  logic                       in_echo_level,
  input  logic [31:0]                in_time_us,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_fire_trigger,
  output logic [1:0]                 out_fired_sensor,
  output logic [9:0]                 out_dist_left_cm,
  output logic [9:0]                 out_dist_center_cm,
  output logic [9:0]                 out_dist_right_cm,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [urr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import urr_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    adv;
  logic    in_fire;

  // the input word moves on whenever the result register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.opcode       <= opcode_t'(in_opcode);
      s1_item_r.sensor_index <= in_sensor_index;
      s1_item_r.echo_level   <= in_echo_level;
      s1_item_r.time_us      <= in_time_us;
    end
  end

  urr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // state is committed in the same edge that loads the result register
  urr_core #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= core_res;
  end

  assign out_valid          = out_valid_r;
  assign out_fire_trigger   = out_res_r.fire_trigger;
  assign out_fired_sensor   = out_res_r.fired_sensor;
  assign out_dist_left_cm   = out_res_r.dist_left_cm;
  assign out_dist_center_cm = out_res_r.dist_center_cm;
  assign out_dist_right_cm  = out_res_r.dist_right_cm;

endmodule

// ===== src/urr_cfg_regs.sv =====
// APB-style configuration registers of the ranger.
`timescale 1ns / 1ps

module urr_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [urr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output urr_pkg::cfg_t             cfg
);
  import urr_pkg::*;

  logic [19:0] timeout_r;
  logic [9:0]  no_echo_r;
  reg_idx_t    reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= RESET_TIMEOUT;
      no_echo_r <= RESET_DIST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TIMEOUT: timeout_r <= pwdata[19:0];
        REG_NO_ECHO: no_echo_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TIMEOUT: prdata = {12'd0, timeout_r};
      REG_NO_ECHO: prdata = {22'd0, no_echo_r};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.timeout_us = timeout_r;
  assign cfg.no_echo_cm = no_echo_r;

endmodule

// ===== src/urr_core.sv =====
// Sensor state and the single-pass update for one poll or echo word.
`timescale 1ns / 1ps

module urr_core #(
  parameter int NUM_SENSORS = urr_pkg::NUM_SENSORS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  urr_pkg::item_t   item,
  input  urr_pkg::cfg_t    cfg,
  output urr_pkg::result_t res
);
  import urr_pkg::*;

  localparam int NS_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int VIEW_N = (NUM_SENSORS > 3) ? NUM_SENSORS : 3;

  logic [31:0] rise_r   [NUM_SENSORS];
  logic [31:0] rise_nxt [NUM_SENSORS];
  logic [31:0] trig_r   [NUM_SENSORS];
  logic [31:0] trig_nxt [NUM_SENSORS];
  logic [9:0]  dist_r   [NUM_SENSORS];
  logic [9:0]  dist_nxt [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] busy_r, busy_nxt;
  logic [NS_W-1:0] next_r, next_nxt;

  logic [NS_W-1:0] ptr;
  logic            ptr_busy;
  logic [31:0]     sel_rise;
  logic            sel_busy;
  logic [9:0]      echo_cm;
  logic [9:0]      dist_view [VIEW_N];

  // reciprocal multiply; 16x16 product, quotient taken from bits RECIP_SHIFT+9 down to RECIP_SHIFT
  function automatic logic [9:0] pulse_to_cm(input logic [31:0] pulse);
    logic [31:0] prod;
    prod = {16'd0, pulse[15:0]} * {16'd0, RECIP_MULT};
    if (pulse >= SAT_LIMIT) return DIST_MAX;
    return prod[RECIP_SHIFT+9:RECIP_SHIFT];
  endfunction

  always_comb begin
    rise_nxt = rise_r;
    trig_nxt = trig_r;
    dist_nxt = dist_r;
    busy_nxt = busy_r;
    next_nxt = next_r;
    res.fire_trigger = 1'b0;
    res.fired_sensor = 2'd0;
    sel_rise = 32'd0;
    sel_busy = 1'b0;
    ptr_busy = 1'b0;
    ptr      = ({1'b0, next_r} >= (NS_W+1)'(NUM_SENSORS)) ? '0 : next_r;

    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (int'(item.sensor_index) == k) begin
        sel_rise = sel_rise | rise_r[k];
        sel_busy = sel_busy | busy_r[k];
      end
    end
    echo_cm = pulse_to_cm(item.time_us - sel_rise);

    if (item.opcode == OP_POLL) begin
      // expire first, so a sensor timed out now can fire in the same poll
      for (int k = 0; k < NUM_SENSORS; k++) begin
        if (busy_r[k] && ((item.time_us - trig_r[k]) > {12'd0, cfg.timeout_us})) begin
          dist_nxt[k] = cfg.no_echo_cm;
          busy_nxt[k] = 1'b0;
        end
      end
      for (int k = 0; k < NUM_SENSORS; k++) begin
        if (int'(ptr) == k) ptr_busy = ptr_busy | busy_nxt[k];
      end
      if (!ptr_busy) begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
          if (int'(ptr) == k) begin
            trig_nxt[k] = item.time_us;
            busy_nxt[k] = 1'b1;
          end
        end
        res.fire_trigger = 1'b1;
        res.fired_sensor = 2'(ptr);
        next_nxt = ({1'b0, ptr} == (NS_W+1)'(NUM_SENSORS - 1)) ? '0 : ptr + 1'b1;
      end
    end else begin
      // an index past the last sensor matches no lane and is dropped
      for (int k = 0; k < NUM_SENSORS; k++) begin
        if (int'(item.sensor_index) == k) begin
          if (item.echo_level) begin
            rise_nxt[k] = item.time_us;
          end else if (sel_busy) begin
            dist_nxt[k] = echo_cm;
            busy_nxt[k] = 1'b0;
          end
        end
      end
    end

    for (int k = 0; k < VIEW_N; k++) dist_view[k] = 10'd0;
    for (int k = 0; k < NUM_SENSORS; k++) dist_view[k] = dist_nxt[k];
    res.dist_left_cm   = dist_view[0];
    res.dist_center_cm = dist_view[1];
    res.dist_right_cm  = dist_view[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        rise_r[k] <= 32'd0;
        trig_r[k] <= 32'd0;
        dist_r[k] <= RESET_DIST;
      end
      busy_r <= '0;
      next_r <= '0;
    end else if (en) begin
      rise_r <= rise_nxt;
      trig_r <= trig_nxt;
      dist_r <= dist_nxt;
      busy_r <= busy_nxt;
      next_r <= next_nxt;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the ultrasonic round-robin ranger unit.
`timescale 1ns / 1ps

module testbench;
  import urr_pkg::*;

  // Sensor count of the default build; the predictor follows it.
  localparam int NS = NUM_SENSORS_DEF;

  localparam logic [1:0] SENSOR_LEFT   = 2'd0;
  localparam logic [1:0] SENSOR_CENTER = 2'd1;
  localparam logic [1:0] SENSOR_RIGHT  = 2'd2;
  localparam logic [1:0] SENSOR_NONE   = 2'd3;  // not fitted, edges ignored
  localparam logic       LEVEL_RISE    = 1'b1;
  localparam logic       LEVEL_FALL    = 1'b0;

  // Depth of the unit from input accept to result word: input register, then result register.
  localparam int LATENCY        = 2;
  // Long receiver hold-off; long enough to back the unit up to its input.
  localparam int HOLD_CYCLES    = 150;
  // Slowest honest stretch without any accept: hold-off plus a stall burst,
  // or a pair of register writes. Taken many times over.
  localparam int WATCHDOG_LIMIT = 4000;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT connections
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_opcode = 1'b0;
  logic [1:0]  in_sensor_index = '0;
  logic        in_echo_level = 1'b0;
  logic [31:0] in_time_us = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_fire_trigger;
  logic [1:0]  out_fired_sensor;
  logic [9:0]  out_dist_left_cm;
  logic [9:0]  out_dist_center_cm;
  logic [9:0]  out_dist_right_cm;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ultrasonic_round_robin_ranger_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_sensor_index    (in_sensor_index),
    .in_echo_level      (in_echo_level),
    .in_time_us         (in_time_us),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fire_trigger   (out_fire_trigger),
    .out_fired_sensor   (out_fired_sensor),
    .out_dist_left_cm   (out_dist_left_cm),
    .out_dist_center_cm (out_dist_center_cm),
    .out_dist_right_cm  (out_dist_right_cm),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // ---------------------------------------------------------------------------
  // Ranger predictor: its own copy of the sensor state and registers
  // ---------------------------------------------------------------------------
  logic [31:0] rise_at   [NS];  // time of the latest rising echo edge
  logic [31:0] fired_at  [NS];  // time the sensor was last triggered
  logic [9:0]  range_cm  [NS];  // latest distance
  logic        measuring [NS];  // triggered, echo not yet finished
  int unsigned rr_ptr;          // round-robin pointer
  logic [19:0] timeout_cfg;
  logic [9:0]  no_echo_cfg;

  function automatic logic [9:0] dist_at(int k);
    if (k < NS) return range_cm[k];
    return '0;  // sensor not fitted in this build
  endfunction

  // Applies one input word to the predictor and returns the result word.
  function automatic result_t ranger_step(item_t w);
    result_t     r;
    logic [31:0] waited;
    logic [31:0] pulse;
    logic [31:0] cm;
    int          s;
    r = '0;
    s = int'(w.sensor_index);
    if (w.opcode == OP_POLL) begin
      // expire first, so a sensor timed out by this poll can fire again now
      for (int k = 0; k < NS; k++) begin
        waited = w.time_us - fired_at[k];
        if (measuring[k] && waited > 32'(timeout_cfg)) begin
          range_cm[k]  = no_echo_cfg;
          measuring[k] = 1'b0;
        end
      end
      if (rr_ptr >= NS) rr_ptr = 0;
      // a busy pointed sensor blocks the poll: no trigger, pointer holds
      if (!measuring[rr_ptr]) begin
        fired_at[rr_ptr]  = w.time_us;
        measuring[rr_ptr] = 1'b1;
        r.fire_trigger    = 1'b1;
        r.fired_sensor    = 2'(rr_ptr);
        rr_ptr            = (rr_ptr + 1) % NS;
      end
    end else if (s < NS) begin
      if (w.echo_level == LEVEL_RISE) begin
        rise_at[s] = w.time_us;  // recorded even when idle
      end else if (measuring[s]) begin
        pulse        = w.time_us - rise_at[s];
        cm           = pulse / 32'd58;
        range_cm[s]  = (cm > 32'(DIST_MAX)) ? DIST_MAX : cm[9:0];
        measuring[s] = 1'b0;
      end
      // falling edge on an idle sensor: nothing changes
    end
    r.dist_left_cm   = dist_at(0);
    r.dist_center_cm = dist_at(1);
    r.dist_right_cm  = dist_at(2);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  item_t       in_words[$];   // input words not yet offered
  result_t     exp_words[$];  // result words owed by the unit, oldest first
  item_t       drv_word;      // word currently on the input port
  logic        offering = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;
  logic        quiet = 1'b0;  // no idling in the closing phase
  int          errors = 0;
  int          stuck_cycles = 0;
  logic [31:0] t_cur;         // stimulus time cursor, wraps freely
  logic [1:0]  gen_ptr;       // stimulus guess at the round-robin pointer

  // ---------------------------------------------------------------------------
  // Input driver: offers queued words, random idle bursts between words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_words.push_back(ranger_step(drv_word));
        offering = 1'b0;
      end
      // one nonblocking write of in_valid per edge, so back-to-back words
      // keep valid high without a glitch
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (in_words.size() > 0) begin
          drv_word = in_words.pop_front();
          offering = 1'b1;
          in_valid        <= 1'b1;
          in_opcode       <= drv_word.opcode;
          in_sensor_index <= drv_word.sensor_index;
          in_echo_level   <= drv_word.echo_level;
          in_time_us      <= drv_word.time_us;
          if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted word, drives out_ready
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_words.size() == 0) begin
          errors++;
          $display("%0t result word: expected none, actual fire=%0d sensor=%0d dist=%0d/%0d/%0d",
                   $time, out_fire_trigger, out_fired_sensor, out_dist_left_cm,
                   out_dist_center_cm, out_dist_right_cm);
        end else begin
          want = exp_words.pop_front();
          check_field("fire_trigger", want.fire_trigger, out_fire_trigger);
          check_field("fired_sensor", want.fired_sensor, out_fired_sensor);
          check_field("dist_left_cm", want.dist_left_cm, out_dist_left_cm);
          check_field("dist_center_cm", want.dist_center_cm, out_dist_center_cm);
          check_field("dist_right_cm", want.dist_right_cm, out_dist_right_cm);
        end
      end
      // long hold-off is counted here, while the sender keeps offering
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 7);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no word moving on either side ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no word accepted for %0d cycles", $time, stuck_cycles);
        $display("[ultrasonic_round_robin_ranger_unit] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(opcode_t op, logic [1:0] idx, logic lvl, logic [31:0] t);
    item_t w;
    w.opcode       = op;
    w.sensor_index = idx;
    w.echo_level   = lvl;
    w.time_us      = t;
    in_words.push_back(w);
  endtask

  // Time between polls: mostly short, sometimes past any timeout, rarely a
  // jump anywhere in the 32-bit range.
  function automatic logic [31:0] poll_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 19) return '0;
    if (pick == 18) return $urandom();
    if (pick >= 16) return $urandom_range(0, 1100000);
    if (pick >= 12) return $urandom_range(3000, 70000);
    return $urandom_range(0, 3000);
  endfunction

  // Echo pulse width: under one cm, around the saturation knee, ordinary,
  // long, or any 32-bit span (wraps).
  function automatic logic [31:0] echo_width();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return $urandom_range(0, 57);
    if (pick == 1) return $urandom_range(59234, 59434);
    if (pick == 6) return $urandom_range(0, 1100000);
    if (pick == 7) return $urandom();
    return $urandom_range(58, 60000);
  endfunction

  // Mostly well-formed poll / rise / fall sequences with random timing,
  // some overlapping measurements on all three sensors, and some noise.
  task automatic add_ranging(int n);
    int          made;
    int          pick;
    int          first;
    logic [31:0] rise_t [3];
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        t_cur += poll_gap();
        add_word(OP_POLL, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), t_cur);
        t_cur += $urandom_range(0, 600);
        add_word(OP_ECHO, gen_ptr, LEVEL_RISE, t_cur);
        t_cur += echo_width();
        add_word(OP_ECHO, gen_ptr, LEVEL_FALL, t_cur);
        gen_ptr = (gen_ptr == SENSOR_RIGHT) ? SENSOR_LEFT : gen_ptr + 2'd1;
        made += 3;
      end else if (pick <= 8) begin
        // three polls back to back, echoes overlapping, falls in a rotated order
        for (int k = 0; k < 3; k++) begin
          t_cur += $urandom_range(0, 2000);
          add_word(OP_POLL, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), t_cur);
        end
        for (int k = 0; k < 3; k++) begin
          rise_t[k] = t_cur + $urandom_range(0, 800);
          add_word(OP_ECHO, 2'(k), LEVEL_RISE, rise_t[k]);
        end
        first = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
          add_word(OP_ECHO, 2'((first + k) % 3), LEVEL_FALL,
                   rise_t[(first + k) % 3] + echo_width());
        t_cur += $urandom_range(0, 70000);
        made += 9;
      end else begin
        // noise: any field values, including the unfitted sensor index
        for (int k = $urandom_range(1, 4); k > 0; k--) begin
          if ($urandom_range(0, 1)) t_cur += $urandom_range(0, 5000);
          else t_cur = $urandom();
          add_word(opcode_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), t_cur);
          made++;
        end
      end
    end
  endtask

  // Waits until every queued word has gone in and every result word has come
  // out; the unit is then idle and registers may be rewritten.
  task automatic drain();
    while (in_words.size() > 0 || offering || exp_words.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is tied high.
  task automatic apb_write(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // registers keep only their field width
    case (r)
      REG_TIMEOUT: timeout_cfg = v[19:0];
      REG_NO_ECHO: no_echo_cfg = v[9:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < NS; k++) begin
      rise_at[k]   = '0;
      fired_at[k]  = '0;
      range_cm[k]  = RESET_DIST;
      measuring[k] = 1'b0;
    end
    rr_ptr      = 0;
    timeout_cfg = RESET_TIMEOUT;
    no_echo_cfg = RESET_DIST;
    t_cur       = '0;
    gen_ptr     = SENSOR_LEFT;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words on reset registers (timeout 30000 us, no-echo 400 cm).
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd0);       // fires left
    add_word(OP_ECHO, SENSOR_LEFT,   LEVEL_RISE, 32'd100);
    add_word(OP_ECHO, SENSOR_LEFT,   LEVEL_FALL, 32'd5900);    // 100 cm
    add_word(OP_ECHO, SENSOR_LEFT,   LEVEL_FALL, 32'd6000);    // idle fall, ignored
    add_word(OP_ECHO, SENSOR_NONE,   LEVEL_RISE, 32'd6100);    // no such sensor
    add_word(OP_ECHO, SENSOR_NONE,   LEVEL_FALL, 32'd6200);
    add_word(OP_ECHO, SENSOR_CENTER, LEVEL_RISE, 32'd7000);    // rise while idle
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd8000);    // fires centre
    add_word(OP_ECHO, SENSOR_CENTER, LEVEL_FALL, 32'd77000);   // long pulse, saturates
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd78000);   // fires right
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd79000);   // fires left
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd80000);   // fires centre
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd81000);   // right busy: no fire
    add_word(OP_POLL, SENSOR_NONE,   LEVEL_RISE, 32'd200000);  // all expire, right fires
    add_word(OP_ECHO, SENSOR_RIGHT,  LEVEL_RISE, 32'hFFFF_FF00);
    add_word(OP_ECHO, SENSOR_RIGHT,  LEVEL_FALL, 32'h0000_0100); // pulse across the wrap
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'hFFFF_FFFF); // fires left
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd29999);   // left waited exactly timeout
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd30000);   // one over: left expires
    add_word(OP_ECHO, SENSOR_CENTER, LEVEL_RISE, 32'd0);
    add_word(OP_ECHO, SENSOR_CENTER, LEVEL_FALL, 32'd0);       // zero-width pulse
    add_word(OP_ECHO, SENSOR_RIGHT,  LEVEL_FALL, 32'h1234_5678); // huge pulse, saturates
    add_word(OP_POLL, SENSOR_LEFT,   LEVEL_FALL, 32'd40000);
    drain();
    t_cur = 32'd50000;

    // Timeout of 1 us, zero no-echo distance: nearly every poll expires.
    apb_write(REG_TIMEOUT, 32'd1);
    apb_write(REG_NO_ECHO, 32'd0);
    add_ranging(200);
    drain();

    // Long timeout (1000000 us), largest no-echo distance; the receiver holds off
    // mid-phase so the unit fills and pushes back on its input.
    apb_write(REG_TIMEOUT, 32'd1000000);
    apb_write(REG_NO_ECHO, 32'd1023);
    add_ranging(350);
    while (in_words.size() > 250) @(posedge clk);
    hold_req = 1'b1;
    drain();

    // Upper bits set in the written words: only the field bits count.
    apb_write(REG_TIMEOUT, 32'hFFF0_0000 | 32'd20000);
    apb_write(REG_NO_ECHO, 32'hABCD_FC00 | 32'd777);
    add_ranging(400);
    drain();

    apb_write(REG_TIMEOUT, 32'($urandom_range(1, 1000000)));
    apb_write(REG_NO_ECHO, 32'($urandom_range(0, 1023)));
    add_ranging(500);
    drain();

    // Closing phase at the reset settings, full rate on both sides.
    quiet = 1'b1;
    apb_write(REG_TIMEOUT, 32'(RESET_TIMEOUT));
    apb_write(REG_NO_ECHO, 32'(RESET_DIST));
    add_ranging(480);
    drain();

    // let any stray result word show itself before the verdict
    repeat (4 * LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("[ultrasonic_round_robin_ranger_unit] OK");
    end else begin
      $display("[ultrasonic_round_robin_ranger_unit] ERROR");
    end
    $finish;
  end

endmodule
